/* design/tcp_udp_checksum_verifier_core_assert.svh */
// Assertion macros for the TCP/UDP checksum verifier.
// Included by the top level; no other dependencies.
`ifndef TCP_UDP_CHECKSUM_VERIFIER_CORE_ASSERT_SVH
`define TCP_UDP_CHECKSUM_VERIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TUCV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tucv check failed");
`define TUCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tucv check failed");
`else
`define TUCV_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TUCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/tucv_pkg.sv */
// Shared types, constants and functions of the TCP/UDP checksum verifier.
// No dependencies.
package tucv_pkg;

    localparam logic [7:0]  PROTO_NUM_TCP = 8'd6;
    localparam logic [15:0] ONES_TARGET = 16'hFFFF;
    localparam logic [15:0] WCNT_MAX    = 16'hFFFF;
    localparam logic [4:0]  MIN_HDR_WORDS = 5'd10;
    localparam logic [3:0]  MIN_IHL     = 4'd5;
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [15:0] add_a;
        logic [15:0] add_b;
        logic        last;
        logic        tcp;
        logic        zskip;
        logic        trunc;
    } entry_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

/* design/tucv_front.sv */
// Front end: parses the IPv4 header and classifies each word into queue entries.
// Depends on tucv_pkg.
module tucv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] packet_word
    input  logic              s_axis_tlast,
    input  logic              q_full,
    output logic              q_wr_en,
    output tucv_pkg::entry_t  q_wr_data
);

    logic [15:0] wcnt_reg, wcnt_next;
    logic [4:0]  hw_reg, hw_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] seglen_reg, seglen_next;
    logic        uzero_reg, uzero_next;

    logic [15:0] w;
    logic        acc;
    logic [4:0]  hw_idx0, hw_cur;
    logic [15:0] tlen_cur, seglen_cur, s_idx, wcnt_inc, seg_words;
    logic [7:0]  proto_cur;
    logic        tcp, in_seg, uzero_cur, trunc;
    logic [16:0] b17;
    logic [15:0] bounded, add_a, add_b;

    assign w             = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign acc           = s_axis_tvalid && !q_full;
    assign q_wr_en       = acc;

    always_comb begin
        hw_idx0   = (w[11:8] < tucv_pkg::MIN_IHL) ? tucv_pkg::MIN_HDR_WORDS : {w[11:8], 1'b0};
        hw_cur    = (wcnt_reg == 16'd0) ? hw_idx0 : hw_reg;
        tlen_cur  = (wcnt_reg == 16'd1) ? w : tlen_reg;
        proto_cur = (wcnt_reg == 16'd4) ? w[7:0] : proto_reg;
        tcp       = (proto_cur == tucv_pkg::PROTO_NUM_TCP);
        in_seg    = (wcnt_reg >= {11'd0, hw_cur});
        s_idx     = wcnt_reg - {11'd0, hw_cur};

        seglen_cur = seglen_reg;
        if (in_seg && tcp && s_idx == 16'd0) begin
            seglen_cur = tlen_cur - {10'd0, hw_cur, 1'b0};
        end else if (in_seg && !tcp && s_idx == 16'd2) begin
            seglen_cur = w;
        end

        b17 = {s_idx, 1'b0};
        if (b17 < {1'b0, seglen_cur}) begin
            bounded = ((b17 + 17'd1) == {1'b0, seglen_cur}) ? {w[15:8], 8'd0} : w;
        end else begin
            bounded = 16'd0;
        end

        add_a = 16'd0;
        if (wcnt_reg == 16'd4) begin
            add_a = {8'd0, w[7:0]};
        end else if (wcnt_reg inside {[16'd6:16'd9]}) begin
            add_a = w;
        end else if (in_seg && tcp && s_idx == 16'd0) begin
            add_a = seglen_cur;
        end else if (in_seg && !tcp && s_idx == 16'd2) begin
            add_a = w;
        end

        add_b = 16'd0;
        if (in_seg) begin
            add_b = (!tcp && s_idx < 16'd2) ? w : bounded;
        end

        uzero_cur = uzero_reg || (in_seg && !tcp && s_idx == 16'd3 && w == 16'd0);
        wcnt_inc  = (wcnt_reg == tucv_pkg::WCNT_MAX) ? wcnt_reg : wcnt_reg + 16'd1;
        seg_words = (wcnt_inc > {11'd0, hw_cur}) ? wcnt_inc - {11'd0, hw_cur} : 16'd0;
        trunc     = (!tcp && seg_words < 16'd3) || ({seg_words, 1'b0} < {1'b0, seglen_cur});

        q_wr_data.add_a = add_a;
        q_wr_data.add_b = add_b;
        q_wr_data.last  = s_axis_tlast;
        q_wr_data.tcp   = tcp;
        q_wr_data.zskip = !tcp && uzero_cur;
        q_wr_data.trunc = trunc;
    end

    always_comb begin
        wcnt_next   = wcnt_reg;
        hw_next     = hw_reg;
        tlen_next   = tlen_reg;
        proto_next  = proto_reg;
        seglen_next = seglen_reg;
        uzero_next  = uzero_reg;
        if (acc) begin
            if (s_axis_tlast) begin
                wcnt_next   = 16'd0;
                hw_next     = 5'd0;
                tlen_next   = 16'd0;
                proto_next  = 8'd0;
                seglen_next = 16'd0;
                uzero_next  = 1'b0;
            end else begin
                wcnt_next   = wcnt_inc;
                hw_next     = hw_cur;
                tlen_next   = tlen_cur;
                proto_next  = proto_cur;
                seglen_next = seglen_cur;
                uzero_next  = uzero_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg   <= 16'd0;
            hw_reg     <= 5'd0;
            tlen_reg   <= 16'd0;
            proto_reg  <= 8'd0;
            seglen_reg <= 16'd0;
            uzero_reg  <= 1'b0;
        end else begin
            wcnt_reg   <= wcnt_next;
            hw_reg     <= hw_next;
            tlen_reg   <= tlen_next;
            proto_reg  <= proto_next;
            seglen_reg <= seglen_next;
            uzero_reg  <= uzero_next;
        end
    end

endmodule

/* design/tucv_queue.sv */
// Short queue of classified words between front and back end.
// Depends on tucv_pkg.
module tucv_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  tucv_pkg::entry_t  wr_data,
    input  logic              rd_en,
    output tucv_pkg::entry_t  rd_data,
    output logic              full,
    output logic              empty
);

    tucv_pkg::entry_t mem_reg [tucv_pkg::QDEPTH];
    logic [tucv_pkg::QAW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [tucv_pkg::QAW:0]   count_reg, count_next;

    localparam logic [tucv_pkg::QAW-1:0] PTR_LAST = tucv_pkg::QAW'(tucv_pkg::QDEPTH - 1);
    localparam logic [tucv_pkg::QAW:0]   CNT_FULL = (tucv_pkg::QAW + 1)'(tucv_pkg::QDEPTH);

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/tucv_back.sv */
// Back end: one's-complement accumulator and result output register.
// Depends on tucv_pkg.
module tucv_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  tucv_pkg::entry_t  q_rd_data,
    output logic              q_rd_en,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [0] checksum_ok [1] zero_checksum_skip
                                              // [2] is_tcp [3] truncated
);

    logic [15:0] sum_reg, sum_next, sum1, sum2;
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  res_reg, res_next;
    logic        out_free, ok;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign q_rd_en       = !q_empty && (!q_rd_data.last || out_free);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg};

    always_comb begin
        sum1 = tucv_pkg::ones_add(sum_reg, q_rd_data.add_a);
        sum2 = tucv_pkg::ones_add(sum1, q_rd_data.add_b);
        ok   = q_rd_data.zskip || (!q_rd_data.trunc && sum2 == tucv_pkg::ONES_TARGET);

        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_rd_en) begin
            if (q_rd_data.last) begin
                sum_next     = 16'd0;
                m_valid_next = 1'b1;
                res_next     = {q_rd_data.trunc, q_rd_data.tcp, q_rd_data.zskip, ok};
            end else begin
                sum_next = sum2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/tcp_udp_checksum_verifier_core.sv */
// TCP/UDP checksum verifier with IPv4 pseudo-header: front parser, queue, back accumulator.
// Throughput: one packet word per cycle while the queue is not full; a packet's result passes through
// the queue and then the output valid register, and is held back while m_axis still holds an earlier result.
// Rate is set by the two chained combinational 16-bit end-around-carry adds in the back end.
// Reset: synchronous, active low; clears parser state, queue, accumulator and output valid.
// Depends on tucv_pkg, tucv_front, tucv_queue, tucv_back and the assertion header.
`include "tcp_udp_checksum_verifier_core_assert.svh"
module tcp_udp_checksum_verifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] packet_word
    input  logic        s_axis_tlast,   // end_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] checksum_ok [1] zero_checksum_skip
                                        // [2] is_tcp [3] truncated [7:4] zero
);

    tucv_pkg::entry_t q_wr_data, q_rd_data;
    logic q_wr_en, q_rd_en, q_full, q_empty;

    tucv_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_wr_en       (q_wr_en),
        .q_wr_data     (q_wr_data)
    );

    tucv_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    tucv_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_rd_data     (q_rd_data),
        .q_rd_en       (q_rd_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `TUCV_ASSERT_NEXT(a_last_pop_gives_result, aclk, aresetn, q_rd_en && q_rd_data.last, m_axis_tvalid)
    `TUCV_ASSERT_SAME(a_trunc_not_ok, aclk, aresetn, m_axis_tvalid && m_axis_tdata[3] && !m_axis_tdata[1], !m_axis_tdata[0])
    `TUCV_ASSERT_SAME(a_skip_is_udp, aclk, aresetn, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[2] && m_axis_tdata[0])
    `TUCV_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, q_empty, !q_rd_en)

endmodule
